// ----- rtl/gsd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gsd_pkg
// Shared types and constants of the gated sawtooth diffusion evaluator.
// ----------------------------------------------------------------------------
package gsd_pkg;

    // cells in the time / position remainder chain and in the interpolation chain
    localparam int unsigned MOD_CELLS  = 32;
    localparam int unsigned LERP_CELLS = 33;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_RISE_LENGTH   = 3'd0,
        REG_FALL_LENGTH   = 3'd1,
        REG_COEFF_HIGH    = 3'd2,
        REG_COEFF_LOW     = 3'd3,
        REG_COEFF_REGULAR = 3'd4,
        REG_LIGHT_PERIOD  = 3'd5,
        REG_LIGHT_ON_TIME = 3'd6,
        REG_STEP_SCALE    = 3'd7
    } cfg_index_t;

    // configuration register reset values
    localparam logic [29:0] RISE_LENGTH_RST   = 30'd65536;
    localparam logic [29:0] FALL_LENGTH_RST   = 30'd65536;
    localparam logic [31:0] COEFF_HIGH_RST    = 32'd65536;
    localparam logic [31:0] COEFF_LOW_RST     = 32'd0;
    localparam logic [31:0] COEFF_REGULAR_RST = 32'd0;
    localparam logic [31:0] LIGHT_PERIOD_RST  = 32'd65536;
    localparam logic [31:0] LIGHT_ON_TIME_RST = 32'd65536;
    localparam logic [31:0] STEP_SCALE_RST    = 32'd65536;

    // configuration bundle
    typedef struct packed {
        logic [29:0] rise_length;
        logic [29:0] fall_length;
        logic [31:0] coeff_high;
        logic [31:0] coeff_low;
        logic [31:0] coeff_regular;
        logic [31:0] light_period;
        logic [31:0] light_on_time;
        logic [31:0] step_scale;
    } cfg_t;

    // one restoring division lane: partial remainder, dividend bits
    // (msb first, quotient bits enter at the lsb) and divisor
    typedef struct packed {
        logic [31:0] rem;
        logic [63:0] num;
        logic [31:0] div;
    } lane_t;

    // side data that travels with an item through the cells
    typedef struct packed {
        logic [31:0] tm;
        logic        neg;
        logic        on;
        logic [31:0] from;
        logic        up;
        logic [31:0] mag;
        logic        nzero;
    } tag_t;

endpackage

`default_nettype wire

// ----- rtl/gsd_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gsd_cell
// One cell of a division chain: a restoring step on two lanes and a
// pipeline register with its own valid bit.
// ----------------------------------------------------------------------------
module gsd_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           up_valid,
    output logic                up_ready,
    input  wire gsd_pkg::tag_t  up_tag,
    input  wire gsd_pkg::lane_t up_lane_a,
    input  wire gsd_pkg::lane_t up_lane_b,
    output logic                dn_valid,
    input  wire logic           dn_ready,
    output gsd_pkg::tag_t       dn_tag,
    output gsd_pkg::lane_t      dn_lane_a,
    output gsd_pkg::lane_t      dn_lane_b
);
    import gsd_pkg::*;

    // one remainder step, quotient bit shifted in at the bottom
    function automatic lane_t div_step(input lane_t l);
        logic [32:0] rem2;
        logic [33:0] diff;
        lane_t       r;
        rem2 = {l.rem, l.num[63]};
        diff = {1'b0, rem2} - {2'b00, l.div};
        r = l;
        if (!diff[33])
        begin
            r.rem = diff[31:0];
            r.num = {l.num[62:0], 1'b1};
        end
        else
        begin
            r.rem = rem2[31:0];
            r.num = {l.num[62:0], 1'b0};
        end
        return r;
    endfunction

    logic  valid_reg;
    tag_t  tag_reg;
    lane_t lane_a_reg;
    lane_t lane_b_reg;
    lane_t lane_a_next;
    lane_t lane_b_next;

    // stage takes a transfer when empty or draining
    assign up_ready = !valid_reg || dn_ready;

    assign lane_a_next = div_step(up_lane_a);
    assign lane_b_next = div_step(up_lane_b);

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            tag_reg    <= up_tag;
            lane_a_reg <= lane_a_next;
            lane_b_reg <= lane_b_next;
        end
    end

    assign dn_valid  = valid_reg;
    assign dn_tag    = tag_reg;
    assign dn_lane_a = lane_a_reg;
    assign dn_lane_b = lane_b_reg;

endmodule

`default_nettype wire

// ----- rtl/gsd_mid.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gsd_mid
// Light decision, phase fold, segment pick and interpolation product;
// loads the interpolation division chain.
// ----------------------------------------------------------------------------
module gsd_mid (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire gsd_pkg::cfg_t  cfg,
    input  wire logic           up_valid,
    output logic                up_ready,
    input  wire gsd_pkg::tag_t  up_tag,
    input  wire gsd_pkg::lane_t up_lane_a,
    input  wire gsd_pkg::lane_t up_lane_b,
    output logic                dn_valid,
    input  wire logic           dn_ready,
    output gsd_pkg::tag_t       dn_tag,
    output gsd_pkg::lane_t      dn_lane_a,
    output gsd_pkg::lane_t      dn_lane_b
);
    import gsd_pkg::*;

    logic        v0_reg, v1_reg, v2_reg, v3_reg;
    logic        rdy0, rdy1, rdy2, rdy3;

    // stage 0 registers
    logic        on0_reg;
    logic [30:0] phase0_reg;
    // stage 1 registers
    logic        on1_reg;
    logic [31:0] from1_reg;
    logic        up1_reg;
    logic [31:0] mag1_reg;
    logic [29:0] p1_reg;
    logic [29:0] n1_reg;
    // stage 2 registers
    logic        on2_reg;
    logic [31:0] from2_reg;
    logic        up2_reg;
    logic [31:0] mag2_reg;
    logic [29:0] n2_reg;
    logic [61:0] prod2_reg;
    // stage 3 registers
    tag_t        tag3_reg;
    lane_t       lane3_reg;

    // stage 0 next values
    logic [31:0] tphase;
    logic [30:0] per;
    logic [30:0] rem_b;
    logic [30:0] phase0_next;
    logic        on0_next;
    // stage 1 next values
    logic        rise_seg;
    logic [30:0] fall_off;
    logic [31:0] to1;
    logic [31:0] from1_next;
    logic        up1_next;
    logic [31:0] mag1_next;
    logic [29:0] p1_next;
    logic [29:0] n1_next;
    // stage 2 / 3 next values
    logic [61:0] prod2_next;
    logic [62:0] numer;
    tag_t        tag3_next;
    lane_t       lane3_next;

    assign rdy3 = !v3_reg || dn_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;
    assign up_ready = rdy0;

    // light phase and folded position phase
    always_comb
    begin
        tphase   = (cfg.light_period == 32'd0) ? up_tag.tm : up_lane_a.rem;
        on0_next = tphase < cfg.light_on_time;
        per      = {1'b0, cfg.rise_length} + {1'b0, cfg.fall_length};
        rem_b    = up_lane_b.rem[30:0];
        if (per == 31'd0)
            phase0_next = 31'd0;
        else if (up_tag.neg && (rem_b != 31'd0))
            phase0_next = per - rem_b;
        else
            phase0_next = rem_b;
    end

    // segment pick and span magnitude
    always_comb
    begin
        rise_seg = phase0_reg < {1'b0, cfg.rise_length};
        fall_off = phase0_reg - {1'b0, cfg.rise_length};
        if (rise_seg)
        begin
            from1_next = cfg.coeff_low;
            to1        = cfg.coeff_high;
            p1_next    = phase0_reg[29:0];
            n1_next    = cfg.rise_length;
        end
        else
        begin
            from1_next = cfg.coeff_high;
            to1        = cfg.coeff_low;
            p1_next    = fall_off[29:0];
            n1_next    = cfg.fall_length;
        end
        up1_next  = to1 >= from1_next;
        mag1_next = up1_next ? (to1 - from1_next) : (from1_next - to1);
    end

    // span times phase
    assign prod2_next = {30'd0, mag1_reg} * {32'd0, p1_reg};

    // rounded dividend for the interpolation chain
    always_comb
    begin
        numer           = {1'b0, prod2_reg} + {34'd0, n2_reg[29:1]};
        tag3_next       = '0;
        tag3_next.on    = on2_reg;
        tag3_next.from  = from2_reg;
        tag3_next.up    = up2_reg;
        tag3_next.mag   = mag2_reg;
        tag3_next.nzero = (n2_reg == 30'd0);
        lane3_next.rem  = {2'b00, numer[62:33]};
        lane3_next.num  = {numer[32:0], 31'd0};
        lane3_next.div  = {2'b00, n2_reg};
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                v0_reg <= up_valid;
            if (rdy1)
                v1_reg <= v0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy0 && up_valid)
        begin
            on0_reg    <= on0_next;
            phase0_reg <= phase0_next;
        end
        if (rdy1 && v0_reg)
        begin
            on1_reg   <= on0_reg;
            from1_reg <= from1_next;
            up1_reg   <= up1_next;
            mag1_reg  <= mag1_next;
            p1_reg    <= p1_next;
            n1_reg    <= n1_next;
        end
        if (rdy2 && v1_reg)
        begin
            on2_reg   <= on1_reg;
            from2_reg <= from1_reg;
            up2_reg   <= up1_reg;
            mag2_reg  <= mag1_reg;
            n2_reg    <= n1_reg;
            prod2_reg <= prod2_next;
        end
        if (rdy3 && v2_reg)
        begin
            tag3_reg  <= tag3_next;
            lane3_reg <= lane3_next;
        end
    end

    assign dn_valid  = v3_reg;
    assign dn_tag    = tag3_reg;
    assign dn_lane_a = lane3_reg;
    assign dn_lane_b = '0;

endmodule

`default_nettype wire

// ----- rtl/gsd_tail.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gsd_tail
// Coefficient assembly, step count product and rounding, output register.
// ----------------------------------------------------------------------------
module gsd_tail (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire gsd_pkg::cfg_t  cfg,
    input  wire logic           up_valid,
    output logic                up_ready,
    input  wire gsd_pkg::tag_t  up_tag,
    input  wire gsd_pkg::lane_t up_lane,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [31:0]         coefficient,
    output logic [31:0]         step_count,
    output logic                light_active
);
    import gsd_pkg::*;

    logic        v0_reg, v1_reg, v2_reg;
    logic        rdy0, rdy1, rdy2;
    logic [31:0] coef0_reg, coef1_reg, coef2_reg;
    logic        on0_reg, on1_reg, on2_reg;
    logic [63:0] prod1_reg;
    logic [31:0] count2_reg;

    logic [32:0] quo;
    logic [31:0] quo_clamped;
    logic [31:0] seg_coef;
    logic [31:0] coef0_next;
    logic [63:0] prod1_next;
    logic [32:0] count_sum;
    logic [31:0] count2_next;

    assign rdy2 = !v2_reg || !out_stall;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;
    assign up_ready = rdy0;

    // interpolated coefficient, never past the segment end
    always_comb
    begin
        quo         = up_lane.num[32:0];
        quo_clamped = (quo > {1'b0, up_tag.mag}) ? up_tag.mag : quo[31:0];
        if (up_tag.nzero)
            seg_coef = up_tag.from;
        else if (up_tag.up)
            seg_coef = up_tag.from + quo_clamped;
        else
            seg_coef = up_tag.from - quo_clamped;
        coef0_next = up_tag.on ? seg_coef : cfg.coeff_regular;
    end

    assign prod1_next = {32'd0, coef0_reg} * {32'd0, cfg.step_scale};

    // round to nearest, saturate
    always_comb
    begin
        count_sum   = {1'b0, prod1_reg[63:32]} + {32'd0, prod1_reg[31]};
        count2_next = count_sum[32] ? 32'hFFFF_FFFF : count_sum[31:0];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                v0_reg <= up_valid;
            if (rdy1)
                v1_reg <= v0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy0 && up_valid)
        begin
            coef0_reg <= coef0_next;
            on0_reg   <= up_tag.on;
        end
        if (rdy1 && v0_reg)
        begin
            coef1_reg <= coef0_reg;
            on1_reg   <= on0_reg;
            prod1_reg <= prod1_next;
        end
        if (rdy2 && v1_reg)
        begin
            coef2_reg  <= coef1_reg;
            on2_reg    <= on1_reg;
            count2_reg <= count2_next;
        end
    end

    assign out_valid    = v2_reg;
    assign coefficient  = coef2_reg;
    assign step_count   = count2_reg;
    assign light_active = on2_reg;

endmodule

`default_nettype wire

// ----- rtl/gated_sawtooth_diffusion_eval_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gated_sawtooth_diffusion_eval_unit
// Gated sawtooth diffusion coefficient and step count evaluator.
// ----------------------------------------------------------------------------
// Takes one transfer of (position, sim_time) per clock while in_stall is low
// and returns one transfer of (coefficient, step_count, light_active) per
// item, in order. The path is one input stage, 32 remainder cells that fold
// the time into the light period and the position into the sawtooth period
// side by side, four stages for phase, segment and product, 33 division
// cells for the interpolation and three stages for the step count and output
// register. Each stage holds its own valid bit, so throughput is one item per
// cycle and a stalled output only holds the stages behind it once they fill
// up. Registers are written through cfg_write / cfg_index / cfg_data only
// while no item is in flight; the block does not enforce it, the user must.
module gated_sawtooth_diffusion_eval_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire gsd_pkg::cfg_index_t cfg_index,
    input  wire logic [31:0]         cfg_data,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [31:0]         position,
    input  wire logic [31:0]         sim_time,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [31:0]              coefficient,
    output logic [31:0]              step_count,
    output logic                     light_active
);
    import gsd_pkg::*;

    cfg_t        cfg_reg;

    // input stage
    logic        vin_reg;
    logic        rdy_in;
    tag_t        tag_in_reg;
    lane_t       lane_a_in_reg;
    lane_t       lane_b_in_reg;
    tag_t        tag_in_next;
    lane_t       lane_a_in_next;
    lane_t       lane_b_in_next;
    logic [31:0] pos_mag;
    logic [30:0] saw_period;

    // remainder chain taps
    logic        mc_valid [0:MOD_CELLS];
    logic        mc_ready [0:MOD_CELLS];
    tag_t        mc_tag   [0:MOD_CELLS];
    lane_t       mc_lane_a[0:MOD_CELLS];
    lane_t       mc_lane_b[0:MOD_CELLS];

    // interpolation chain taps
    logic        lc_valid [0:LERP_CELLS];
    logic        lc_ready [0:LERP_CELLS];
    tag_t        lc_tag   [0:LERP_CELLS];
    lane_t       lc_lane_a[0:LERP_CELLS];
    lane_t       lc_lane_b[0:LERP_CELLS];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rise_length   <= RISE_LENGTH_RST;
            cfg_reg.fall_length   <= FALL_LENGTH_RST;
            cfg_reg.coeff_high    <= COEFF_HIGH_RST;
            cfg_reg.coeff_low     <= COEFF_LOW_RST;
            cfg_reg.coeff_regular <= COEFF_REGULAR_RST;
            cfg_reg.light_period  <= LIGHT_PERIOD_RST;
            cfg_reg.light_on_time <= LIGHT_ON_TIME_RST;
            cfg_reg.step_scale    <= STEP_SCALE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RISE_LENGTH:   cfg_reg.rise_length   <= cfg_data[29:0];
                REG_FALL_LENGTH:   cfg_reg.fall_length   <= cfg_data[29:0];
                REG_COEFF_HIGH:    cfg_reg.coeff_high    <= cfg_data;
                REG_COEFF_LOW:     cfg_reg.coeff_low     <= cfg_data;
                REG_COEFF_REGULAR: cfg_reg.coeff_regular <= cfg_data;
                REG_LIGHT_PERIOD:  cfg_reg.light_period  <= cfg_data;
                REG_LIGHT_ON_TIME: cfg_reg.light_on_time <= cfg_data;
                REG_STEP_SCALE:    cfg_reg.step_scale    <= cfg_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // lane setup: time over light period, position magnitude over saw period
    always_comb
    begin
        pos_mag    = position[31] ? (~position + 32'd1) : position;
        saw_period = {1'b0, cfg_reg.rise_length} + {1'b0, cfg_reg.fall_length};
        tag_in_next     = '0;
        tag_in_next.tm  = sim_time;
        tag_in_next.neg = position[31];
        lane_a_in_next.rem = 32'd0;
        lane_a_in_next.num = {sim_time, 32'd0};
        lane_a_in_next.div = cfg_reg.light_period;
        lane_b_in_next.rem = 32'd0;
        lane_b_in_next.num = {pos_mag, 32'd0};
        lane_b_in_next.div = {1'b0, saw_period};
    end

    assign rdy_in   = !vin_reg || mc_ready[0];
    assign in_stall = !rdy_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vin_reg <= 1'b0;
        else if (rdy_in)
            vin_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy_in && in_valid)
        begin
            tag_in_reg    <= tag_in_next;
            lane_a_in_reg <= lane_a_in_next;
            lane_b_in_reg <= lane_b_in_next;
        end
    end

    assign mc_valid[0]  = vin_reg;
    assign mc_tag[0]    = tag_in_reg;
    assign mc_lane_a[0] = lane_a_in_reg;
    assign mc_lane_b[0] = lane_b_in_reg;

    // remainder cells
    for (genvar k = 0; k < MOD_CELLS; k++)
    begin : g_mod
        gsd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .up_valid  (mc_valid[k]),
            .up_ready  (mc_ready[k]),
            .up_tag    (mc_tag[k]),
            .up_lane_a (mc_lane_a[k]),
            .up_lane_b (mc_lane_b[k]),
            .dn_valid  (mc_valid[k+1]),
            .dn_ready  (mc_ready[k+1]),
            .dn_tag    (mc_tag[k+1]),
            .dn_lane_a (mc_lane_a[k+1]),
            .dn_lane_b (mc_lane_b[k+1])
        );
    end

    // phase, segment and product stages
    gsd_mid u_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .up_valid  (mc_valid[MOD_CELLS]),
        .up_ready  (mc_ready[MOD_CELLS]),
        .up_tag    (mc_tag[MOD_CELLS]),
        .up_lane_a (mc_lane_a[MOD_CELLS]),
        .up_lane_b (mc_lane_b[MOD_CELLS]),
        .dn_valid  (lc_valid[0]),
        .dn_ready  (lc_ready[0]),
        .dn_tag    (lc_tag[0]),
        .dn_lane_a (lc_lane_a[0]),
        .dn_lane_b (lc_lane_b[0])
    );

    // interpolation division cells
    for (genvar k = 0; k < LERP_CELLS; k++)
    begin : g_lerp
        gsd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .up_valid  (lc_valid[k]),
            .up_ready  (lc_ready[k]),
            .up_tag    (lc_tag[k]),
            .up_lane_a (lc_lane_a[k]),
            .up_lane_b (lc_lane_b[k]),
            .dn_valid  (lc_valid[k+1]),
            .dn_ready  (lc_ready[k+1]),
            .dn_tag    (lc_tag[k+1]),
            .dn_lane_a (lc_lane_a[k+1]),
            .dn_lane_b (lc_lane_b[k+1])
        );
    end

    // coefficient, step count and output register
    gsd_tail u_tail (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .up_valid     (lc_valid[LERP_CELLS]),
        .up_ready     (lc_ready[LERP_CELLS]),
        .up_tag       (lc_tag[LERP_CELLS]),
        .up_lane      (lc_lane_a[LERP_CELLS]),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .coefficient  (coefficient),
        .step_count   (step_count),
        .light_active (light_active)
    );

    // an empty input stage never stalls the source
    assert property (@(posedge clk) disable iff (!rst_n)
        !vin_reg |-> !in_stall)
        else $error("input stalled with empty input stage");

    // light off gives the regular coefficient
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !light_active) |-> (coefficient == cfg_reg.coeff_regular))
        else $error("light off result differs from regular coefficient");

    // light on stays inside the sawtooth range
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && light_active && (cfg_reg.coeff_low <= cfg_reg.coeff_high))
        |-> ((coefficient >= cfg_reg.coeff_low) && (coefficient <= cfg_reg.coeff_high)))
        else $error("sawtooth coefficient outside low/high range");

endmodule

`default_nettype wire
